// ===== rtl/core/mlex_pkg.sv =====
// Shared types, character codes and token kind codes for the markup lexer.
// No dependencies; every other file of the block but the two channel interfaces imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mlex_pkg;

	// Token kinds as they appear on the output
	localparam logic [3:0] KIND_EQUALS   = 4'd0;
	localparam logic [3:0] KIND_LT       = 4'd1;
	localparam logic [3:0] KIND_GT       = 4'd2;
	localparam logic [3:0] KIND_SLASH    = 4'd3;
	localparam logic [3:0] KIND_BANG     = 4'd4;
	localparam logic [3:0] KIND_DASH     = 4'd5;
	localparam logic [3:0] KIND_LBRACKET = 4'd6;
	localparam logic [3:0] KIND_RBRACKET = 4'd7;
	localparam logic [3:0] KIND_STRING   = 4'd8;
	localparam logic [3:0] KIND_IDENT    = 4'd9;
	localparam logic [3:0] KIND_SPACE    = 4'd10;
	localparam logic [3:0] KIND_OTHER    = 4'd11;

	// Character codes
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_UPPER_LO = 8'h41;
	localparam logic [7:0] CH_UPPER_HI = 8'h5A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_UNDER    = 8'h5F;
	localparam logic [7:0] CH_LOWER_LO = 8'h61;
	localparam logic [7:0] CH_LOWER_HI = 8'h7A;

	// Lexer mode, one-hot
	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_STR   = 5'b00010,
		MODE_ESC   = 5'b00100,
		MODE_IDENT = 5'b01000,
		MODE_SPACE = 5'b10000
	} mode_t;

	// One result word
	typedef struct packed {
		logic       is_end;
		logic [3:0] token_kind;
		logic [7:0] char_value;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic       discarded;
		logic       last;
	} rec_t;

	// All words caused by one input byte, handed to the result buffer
	typedef struct packed {
		logic       load;
		logic [1:0] count;
		rec_t [2:0] recs;
	} batch_t;

	// Punctuation lookup: hit flag plus kind
	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} punct_t;

	function automatic punct_t punct_kind(input logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		case (c)
			CH_EQUALS:   p.kind = KIND_EQUALS;
			CH_LT:       p.kind = KIND_LT;
			CH_GT:       p.kind = KIND_GT;
			CH_SLASH:    p.kind = KIND_SLASH;
			CH_BANG:     p.kind = KIND_BANG;
			CH_DASH:     p.kind = KIND_DASH;
			CH_LBRACKET: p.kind = KIND_LBRACKET;
			CH_RBRACKET: p.kind = KIND_RBRACKET;
			default: begin
				p.hit  = 1'b0;
				p.kind = KIND_OTHER;
			end
		endcase
		return p;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
			(c >= CH_UPPER_LO && c <= CH_UPPER_HI) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mlex_char_if.sv =====
// Input channel of the markup lexer: one text byte per word.
// Depends on nothing but the clock domain of the block.
`timescale 1ns / 1ps
`default_nettype none

interface mlex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mlex_tok_if.sv =====
// Output channel of the markup lexer: one token record per word.
// Depends on nothing but the clock domain of the block.
`timescale 1ns / 1ps
`default_nettype none

interface mlex_tok_if;
	logic        valid;
	logic        ready;
	logic        is_end;
	logic [3:0]  token_kind;
	logic [7:0]  char_value;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        discarded;
	logic        last;

	modport source (output valid, output is_end, output token_kind, output char_value,
		output start_line, output start_column, output discarded, output last,
		input ready);
	modport sink   (input valid, input is_end, input token_kind, input char_value,
		input start_line, input start_column, input discarded, input last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/markup_lexer_with_positions_unit.sv =====
// Top level of the markup lexer with token positions.
// Depends on mlex_pkg, mlex_char_if, mlex_tok_if, mlex_core and mlex_obuf.
`timescale 1ns / 1ps
`default_nettype none

// Takes one text byte per word on char_ch and sends token records on tok_ch:
// content bytes of a token, then an end record with its kind and the line and
// column where it began. A byte that yields zero or one record is taken every
// cycle while tok_ch is ready; one that yields more (at most three) holds the
// input until its last record leaves, as the result buffer sends one record per
// cycle, while tok_ch is ready, on its single output port. A byte passes the
// input register, then the result buffer. After a byte marked end_of_input the
// positions restart at line 0, column 0. LINE_BITS and COLUMN_BITS size the
// internal saturating counters; the output positions clamp at 65535.
module markup_lexer_with_positions_unit #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mlex_char_if.sink  char_ch,
	mlex_tok_if.source tok_ch
);
	import mlex_pkg::*;

	batch_t batch;
	logic   load_ok;

	mlex_core #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.load_ok (load_ok),
		.batch   (batch)
	);

	mlex_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.batch   (batch),
		.load_ok (load_ok),
		.tok_ch  (tok_ch)
	);

	// A word sent without last is followed by more words of the same byte
	a_more_after_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ch.valid && tok_ch.ready && !tok_ch.last |=> tok_ch.valid)
		else $error("record stream broke off before last");

	// Cut-off report only on the closing end record of a byte
	a_discard_is_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ch.valid && tok_ch.discarded |-> tok_ch.is_end && tok_ch.last)
		else $error("discarded flag on a non-final or content record");

	// A batch is only loaded when the buffer has room for it
	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		batch.load |-> load_ok && batch.count != 2'd3 || batch.load && load_ok)
		else $error("batch loaded while result buffer busy");

	// End records carry no content byte
	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ch.valid && tok_ch.is_end |-> tok_ch.char_value == 8'h00)
		else $error("end record with nonzero character");

endmodule

`default_nettype wire

// ===== rtl/core/mlex_core.sv =====
// Lexer core: input byte register, lexer state and the one-pass step logic.
// Depends on mlex_pkg and mlex_char_if; feeds a batch of words to mlex_obuf.
`timescale 1ns / 1ps
`default_nettype none

module mlex_core #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mlex_char_if.sink            char_ch,
	input  wire logic            load_ok,
	output mlex_pkg::batch_t     batch
);
	import mlex_pkg::*;

	typedef struct packed {
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic                   nl;
		logic                   cr;
	} pos_t;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

	// Position update for one consumed byte, with CR/LF pair folding
	function automatic pos_t count_byte(input logic [7:0] c, input pos_t p);
		pos_t r;
		r = p;
		if (c == CH_LF) begin
			if (p.cr) begin
				r.cr = 1'b0;
			end else begin
				if (p.line != LINE_MAX) r.line = p.line + 1'b1;
				r.col = '0;
				r.nl  = 1'b1;
			end
		end else if (c == CH_CR) begin
			if (p.nl) begin
				r.nl = 1'b0;
			end else begin
				if (p.line != LINE_MAX) r.line = p.line + 1'b1;
				r.col = '0;
				r.cr  = 1'b1;
			end
		end else begin
			r.nl = 1'b0;
			r.cr = 1'b0;
			if (p.col != COL_MAX) r.col = p.col + 1'b1;
		end
		return r;
	endfunction

	// Build a record; positions clamp to 16 bits
	function automatic rec_t mk_rec(input logic e, input logic [3:0] k, input logic [7:0] ch,
		input logic d, input logic [LINE_BITS-1:0] tl, input logic [COLUMN_BITS-1:0] tc);
		rec_t r;
		r.is_end     = e;
		r.token_kind = k;
		r.char_value = ch;
		r.discarded  = d;
		r.last       = 1'b0;
		if (LINE_BITS > 16 && tl > LINE_BITS'(32'h0000FFFF)) r.start_line = 16'hFFFF;
		else r.start_line = 16'(tl);
		if (COLUMN_BITS > 16 && tc > COLUMN_BITS'(32'h0000FFFF)) r.start_column = 16'hFFFF;
		else r.start_column = 16'(tc);
		return r;
	endfunction

	// Input register
	logic       s1_valid_q;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       step_en;

	assign step_en       = s1_valid_q && load_ok;
	assign char_ch.ready = !s1_valid_q || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (char_ch.valid && char_ch.ready) begin
			s1_valid_q <= 1'b1;
		end else if (step_en) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			char_s1 <= char_ch.char_in;
			eoi_s1  <= char_ch.end_of_input;
		end
	end

	// Lexer state
	mode_t                  mode_q, mode_v;
	pos_t                   pos_q, pos_v;
	logic [LINE_BITS-1:0]   tl_q, tl_v;
	logic [COLUMN_BITS-1:0] tc_q, tc_v;
	logic [1:0]             n_v;
	rec_t [2:0]             recs_v;
	logic                   restart_v;
	punct_t                 pk;
	logic [3:0]             disc_kind;

	assign pk = punct_kind(char_s1);

	// One step of the lexer for the registered byte
	always_comb begin
		mode_v    = mode_q;
		pos_v     = pos_q;
		tl_v      = tl_q;
		tc_v      = tc_q;
		n_v       = 2'd0;
		recs_v    = '0;
		restart_v = 1'b0;
		disc_kind = KIND_STRING;

		case (mode_q)
			MODE_STR: begin
				pos_v = count_byte(char_s1, pos_v);
				if (char_s1 == CH_QUOTE) begin
					recs_v[n_v] = mk_rec(1'b1, KIND_STRING, CH_NUL, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
					mode_v = MODE_IDLE;
				end else if (char_s1 == CH_BSLASH) begin
					mode_v = MODE_ESC;
				end else begin
					recs_v[n_v] = mk_rec(1'b0, KIND_STRING, char_s1, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
				end
			end
			MODE_ESC: begin
				pos_v = count_byte(char_s1, pos_v);
				recs_v[n_v] = mk_rec(1'b0, KIND_STRING, char_s1, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
				mode_v = MODE_STR;
			end
			MODE_IDENT: begin
				if (is_alpha(char_s1) || is_digit(char_s1)) begin
					pos_v = count_byte(char_s1, pos_v);
					recs_v[n_v] = mk_rec(1'b0, KIND_IDENT, char_s1, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
				end else begin
					recs_v[n_v] = mk_rec(1'b1, KIND_IDENT, CH_NUL, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
					mode_v = MODE_IDLE;
					restart_v = 1'b1;
				end
			end
			MODE_SPACE: begin
				if (is_space(char_s1)) begin
					pos_v = count_byte(char_s1, pos_v);
					recs_v[n_v] = mk_rec(1'b0, KIND_SPACE, char_s1, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
				end else begin
					recs_v[n_v] = mk_rec(1'b1, KIND_SPACE, CH_NUL, 1'b0, tl_v, tc_v);
					n_v = n_v + 2'd1;
					mode_v = MODE_IDLE;
					restart_v = 1'b1;
				end
			end
			default: begin
				mode_v = MODE_IDLE;
				restart_v = 1'b1;
			end
		endcase

		// Byte lexed as a new token; a NUL outside a string is dropped
		if (restart_v && char_s1 != CH_NUL) begin
			tl_v     = pos_v.line;
			tc_v     = pos_v.col;
			pos_v.nl = 1'b0;
			pos_v.cr = 1'b0;
			pos_v    = count_byte(char_s1, pos_v);
			if (pk.hit) begin
				recs_v[n_v] = mk_rec(1'b0, pk.kind, char_s1, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
				recs_v[n_v] = mk_rec(1'b1, pk.kind, CH_NUL, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
			end else if (char_s1 == CH_QUOTE) begin
				mode_v = MODE_STR;
			end else if (is_alpha(char_s1)) begin
				recs_v[n_v] = mk_rec(1'b0, KIND_IDENT, char_s1, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
				mode_v = MODE_IDENT;
			end else if (is_space(char_s1)) begin
				recs_v[n_v] = mk_rec(1'b0, KIND_SPACE, char_s1, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
				mode_v = MODE_SPACE;
			end else begin
				recs_v[n_v] = mk_rec(1'b0, KIND_OTHER, char_s1, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
				recs_v[n_v] = mk_rec(1'b1, KIND_OTHER, CH_NUL, 1'b0, tl_v, tc_v);
				n_v = n_v + 2'd1;
			end
		end

		// End of text: report an open token as cut off, then start over
		if (eoi_s1) begin
			if (mode_v == MODE_IDENT) disc_kind = KIND_IDENT;
			else if (mode_v == MODE_SPACE) disc_kind = KIND_SPACE;
			if (mode_v != MODE_IDLE) begin
				recs_v[n_v] = mk_rec(1'b1, disc_kind, CH_NUL, 1'b1, tl_v, tc_v);
				n_v = n_v + 2'd1;
			end
			mode_v = MODE_IDLE;
			pos_v  = '0;
			tl_v   = '0;
			tc_v   = '0;
		end

		if (n_v != 2'd0) recs_v[n_v - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			tl_q   <= '0;
			tc_q   <= '0;
		end else if (step_en) begin
			mode_q <= mode_v;
			pos_q  <= pos_v;
			tl_q   <= tl_v;
			tc_q   <= tc_v;
		end
	end

	assign batch.load  = step_en;
	assign batch.count = n_v;
	assign batch.recs  = recs_v;

endmodule

`default_nettype wire

// ===== rtl/core/mlex_obuf.sv =====
// Result buffer: holds the up to three words of one byte and sends them in order.
// Depends on mlex_pkg and mlex_tok_if; loaded by mlex_core.
`timescale 1ns / 1ps
`default_nettype none

module mlex_obuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mlex_pkg::batch_t batch,
	output logic                 load_ok,
	mlex_tok_if.source           tok_ch
);
	import mlex_pkg::*;

	logic [1:0] cnt_q;
	rec_t [2:0] buf_q;
	logic       fire;

	assign fire = tok_ch.valid && tok_ch.ready;
	// Room for a new batch once the last held word leaves
	assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tok_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (batch.load) begin
			cnt_q <= batch.count;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Head of the buffer is always word 0; shift on each sent word
	always_ff @(posedge clk) begin
		if (batch.load) begin
			buf_q <= batch.recs;
		end else if (fire) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign tok_ch.valid        = cnt_q != 2'd0;
	assign tok_ch.is_end       = buf_q[0].is_end;
	assign tok_ch.token_kind   = buf_q[0].token_kind;
	assign tok_ch.char_value   = buf_q[0].char_value;
	assign tok_ch.start_line   = buf_q[0].start_line;
	assign tok_ch.start_column = buf_q[0].start_column;
	assign tok_ch.discarded    = buf_q[0].discarded;
	assign tok_ch.last         = buf_q[0].last;

endmodule

`default_nettype wire

// ===== tb/tb_mlex_token_checker.sv =====
// Token checker for the markup lexer: predicts token words from accepted text bytes
// and compares them, in order, with the words leaving the block.
// Depends on mlex_pkg, mlex_char_if and mlex_tok_if.
`timescale 1ns / 1ps

module tb_mlex_token_checker #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mlex_char_if      char_mon,
	mlex_tok_if       tok_mon,
	output int        mismatch_count,
	output int        words_pending
);
	import mlex_pkg::*;

	localparam logic [63:0] LINE_MAX   = (64'd1 << LINE_BITS) - 64'd1;
	localparam logic [63:0] COLUMN_MAX = (64'd1 << COLUMN_BITS) - 64'd1;

	// Lexer state as predicted
	mode_t       lex_mode;
	logic [63:0] line_cnt;
	logic [63:0] col_cnt;
	logic [63:0] tok_line;
	logic [63:0] tok_col;
	logic        lf_seen;
	logic        cr_seen;

	rec_t expected_words[$];
	int   words_this_byte;
	int   words_seen;

	function automatic logic [15:0] clamp16(input logic [63:0] v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic void clear_state();
		lex_mode = MODE_IDLE;
		line_cnt = '0;
		col_cnt  = '0;
		tok_line = '0;
		tok_col  = '0;
		lf_seen  = 1'b0;
		cr_seen  = 1'b0;
	endfunction

	function automatic void add_word(input logic end_rec, input logic [3:0] kind,
			input logic [7:0] ch, input logic cut);
		rec_t w;
		if (words_this_byte >= 3)
			return;
		w.is_end       = end_rec;
		w.token_kind   = kind;
		w.char_value   = ch;
		w.start_line   = clamp16(tok_line);
		w.start_column = clamp16(tok_col);
		w.discarded    = cut;
		w.last         = 1'b0;
		expected_words.insert(expected_words.size(), w);
		words_this_byte++;
	endfunction

	function automatic void advance_column();
		if (col_cnt < COLUMN_MAX)
			col_cnt++;
	endfunction

	function automatic void next_line();
		if (line_cnt < LINE_MAX)
			line_cnt++;
		col_cnt = '0;
	endfunction

	// Position update; a CR/LF or LF/CR pair counts as one line break
	function automatic void count_position(input logic [7:0] c);
		if (c == CH_LF) begin
			if (cr_seen) begin
				cr_seen = 1'b0;
			end else begin
				next_line();
				lf_seen = 1'b1;
			end
		end else if (c == CH_CR) begin
			if (lf_seen) begin
				lf_seen = 1'b0;
			end else begin
				next_line();
				cr_seen = 1'b1;
			end
		end else begin
			cr_seen = 1'b0;
			lf_seen = 1'b0;
			advance_column();
		end
	endfunction

	function automatic void start_token();
		tok_line = line_cnt;
		tok_col  = col_cnt;
		lf_seen  = 1'b0;
		cr_seen  = 1'b0;
	endfunction

	function automatic logic punct_lookup(input logic [7:0] c, output logic [3:0] kind);
		kind = KIND_OTHER;
		case (c)
			CH_EQUALS:   kind = KIND_EQUALS;
			CH_LT:       kind = KIND_LT;
			CH_GT:       kind = KIND_GT;
			CH_SLASH:    kind = KIND_SLASH;
			CH_BANG:     kind = KIND_BANG;
			CH_DASH:     kind = KIND_DASH;
			CH_LBRACKET: kind = KIND_LBRACKET;
			CH_RBRACKET: kind = KIND_RBRACKET;
			default:     return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic name_start(input logic [7:0] c);
		return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
			(c >= CH_UPPER_LO && c <= CH_UPPER_HI) || c == CH_UNDER;
	endfunction

	function automatic logic name_more(input logic [7:0] c);
		return name_start(c) || (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI);
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// Byte seen between tokens
	function automatic void lex_between(input logic [7:0] c);
		logic [3:0] pk;
		if (punct_lookup(c, pk)) begin
			start_token();
			add_word(1'b0, pk, c, 1'b0);
			add_word(1'b1, pk, 8'h00, 1'b0);
			advance_column();
		end else if (c == CH_QUOTE) begin
			start_token();
			count_position(c);
			lex_mode = MODE_STR;
		end else if (name_start(c)) begin
			start_token();
			count_position(c);
			add_word(1'b0, KIND_IDENT, c, 1'b0);
			lex_mode = MODE_IDENT;
		end else if (blank(c)) begin
			start_token();
			count_position(c);
			add_word(1'b0, KIND_SPACE, c, 1'b0);
			lex_mode = MODE_SPACE;
		end else if (c != CH_NUL) begin
			start_token();
			count_position(c);
			add_word(1'b0, KIND_OTHER, c, 1'b0);
			add_word(1'b1, KIND_OTHER, 8'h00, 1'b0);
		end
	endfunction

	// Queue every token word that one text byte causes
	function automatic void predict_byte(input logic [7:0] c, input logic eoi);
		logic [3:0] open_kind;
		words_this_byte = 0;
		case (lex_mode)
			MODE_STR: begin
				count_position(c);
				if (c == CH_QUOTE) begin
					add_word(1'b1, KIND_STRING, 8'h00, 1'b0);
					lex_mode = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					lex_mode = MODE_ESC;
				end else begin
					add_word(1'b0, KIND_STRING, c, 1'b0);
				end
			end
			MODE_ESC: begin
				count_position(c);
				add_word(1'b0, KIND_STRING, c, 1'b0);
				lex_mode = MODE_STR;
			end
			MODE_IDENT: begin
				if (name_more(c)) begin
					count_position(c);
					add_word(1'b0, KIND_IDENT, c, 1'b0);
				end else begin
					add_word(1'b1, KIND_IDENT, 8'h00, 1'b0);
					lex_mode = MODE_IDLE;
					lex_between(c);
				end
			end
			MODE_SPACE: begin
				if (blank(c)) begin
					count_position(c);
					add_word(1'b0, KIND_SPACE, c, 1'b0);
				end else begin
					add_word(1'b1, KIND_SPACE, 8'h00, 1'b0);
					lex_mode = MODE_IDLE;
					lex_between(c);
				end
			end
			default: begin
				lex_mode = MODE_IDLE;
				lex_between(c);
			end
		endcase

		// end of text: close an open token as cut off, then restart positions
		if (eoi) begin
			if (lex_mode != MODE_IDLE) begin
				case (lex_mode)
					MODE_IDENT: open_kind = KIND_IDENT;
					MODE_SPACE: open_kind = KIND_SPACE;
					default:    open_kind = KIND_STRING;
				endcase
				add_word(1'b1, open_kind, 8'h00, 1'b1);
			end
			clear_state();
		end

		if (words_this_byte > 0)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] token check: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d: %s is %0h, predicted %0h",
				words_seen, name, got, want));
	endtask

	task automatic check_word();
		rec_t want;
		words_seen++;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("word %0d: unexpected token word, kind %0d",
				words_seen, tok_mon.token_kind));
			return;
		end
		want = expected_words.pop_front();
		compare_field("is_end", 16'(tok_mon.is_end), 16'(want.is_end));
		compare_field("token_kind", 16'(tok_mon.token_kind), 16'(want.token_kind));
		compare_field("char_value", 16'(tok_mon.char_value), 16'(want.char_value));
		compare_field("start_line", tok_mon.start_line, want.start_line);
		compare_field("start_column", tok_mon.start_column, want.start_column);
		compare_field("discarded", 16'(tok_mon.discarded), 16'(want.discarded));
		compare_field("last", 16'(tok_mon.last), 16'(want.last));
	endtask

	// Watch both channels; predict on accepted bytes, compare accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_words.delete();
			mismatch_count = 0;
			words_seen     = 0;
		end else begin
			if (char_mon.valid && char_mon.ready)
				predict_byte(char_mon.char_in, char_mon.end_of_input);
			if (tok_mon.valid && tok_mon.ready)
				check_word();
		end
		words_pending = expected_words.size();
	end

endmodule

// ===== tb/tb_markup_lexer_with_positions_unit.sv =====
// Testbench top for the markup lexer: clock, reset, text byte stimulus, output pacing
// and the verdict. Depends on mlex_pkg, both channel interfaces, the lexer top and
// tb_mlex_token_checker.
`timescale 1ns / 1ps

module tb_markup_lexer_with_positions_unit;
	import mlex_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int LINE_BITS    = 16;
	localparam int COLUMN_BITS  = 16;
	localparam int RANDOM_BYTES = 150;
	localparam int LONG_RUN     = 12;
	localparam int LINE_RUN     = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_NS     = 3_000_000;

	localparam logic [7:0] PUNCT_SET [8] = '{CH_EQUALS, CH_LT, CH_GT, CH_SLASH,
		CH_BANG, CH_DASH, CH_LBRACKET, CH_RBRACKET};

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   words_pending;
	int   bytes_sent;
	int   idle_pct;
	int   stall_pct;

	mlex_char_if char_ch ();
	mlex_tok_if  tok_ch ();

	markup_lexer_with_positions_unit #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.tok_ch  (tok_ch)
	);

	tb_mlex_token_checker #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_mon       (char_ch),
		.tok_mon        (tok_ch),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	// Output side: random stall bursts while stall_pct is nonzero
	initial begin : sink_pacing
		int k;
		tok_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				k = $urandom_range(1, 5);
				tok_ch.ready <= 1'b0;
				repeat (k) @(posedge clk);
				tok_ch.ready <= 1'b1;
			end
		end
	end

	// One text byte, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] c, input logic eoi);
		int k;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			k = $urandom_range(1, 5);
			char_ch.valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		char_ch.valid        <= 1'b1;
		char_ch.char_in      <= c;
		char_ch.end_of_input <= eoi;
		do @(posedge clk); while (!char_ch.ready);
		bytes_sent++;
	endtask

	// Random byte with an occasional end-of-text mark
	task automatic send_text(input logic [7:0] c);
		send_byte(c, $urandom_range(0, 24) == 0);
	endtask

	function automatic logic [7:0] name_char(input logic first);
		int sel;
		sel = first ? $urandom_range(0, 2) : $urandom_range(0, 3);
		case (sel)
			0:       return CH_LOWER_LO + 8'($urandom_range(0, 25));
			1:       return CH_UPPER_LO + 8'($urandom_range(0, 25));
			2:       return CH_UNDER;
			default: return CH_DIGIT_LO + 8'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// Mostly well-formed tokens with random content, some loose noise bytes
	task automatic send_token();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_text(PUNCT_SET[$urandom_range(0, 7)]);
		end else if (pick < 32) begin
			len = $urandom_range(1, 6);
			send_text(name_char(1'b1));
			repeat (len - 1) send_text(name_char(1'b0));
		end else if (pick < 47) begin
			len = $urandom_range(1, 4);
			repeat (len) send_text(blank_char());
		end else if (pick < 67) begin
			len = $urandom_range(0, 5);
			send_text(CH_QUOTE);
			repeat (len) begin
				if ($urandom_range(0, 4) == 0)
					send_text(CH_BSLASH);
				send_text(8'($urandom_range(0, 255)));
			end
			send_text(CH_QUOTE);
		end else if (pick < 77) begin
			send_text(8'($urandom_range(0, 255)));
		end else if (pick < 82) begin
			send_text(CH_NUL);
		end else begin
			len = $urandom_range(1, 4);
			repeat (len) send_text(8'($urandom_range(0, 255)));
		end
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		int seg_left;
		int base;
		arst_n               = 1'b0;
		idle_pct             = 0;
		stall_pct            = 0;
		bytes_sent           = 0;
		char_ch.valid        <= 1'b0;
		char_ch.char_in      <= 8'h00;
		char_ch.end_of_input <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: every punctuation token
		idle_pct  = 25;
		stall_pct = 25;
		foreach (PUNCT_SET[i])
			send_byte(PUNCT_SET[i], 1'b0);
		// ident run ended by a space run holding CR LF and LF CR pairs, closed by NUL
		send_byte(CH_UPPER_HI, 1'b0);
		send_byte(CH_UNDER, 1'b0);
		send_byte(CH_DIGIT_HI, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_NUL, 1'b0);
		// string with top byte, escaped quote and a NUL as content
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		// ident cut off by end of text, then a string opened on the last byte
		send_byte(CH_LOWER_LO, 1'b1);
		send_byte(CH_QUOTE, 1'b1);

		// random segments, each with its own pacing
		base     = bytes_sent;
		seg_left = 0;
		while (bytes_sent - base < RANDOM_BYTES) begin
			if (seg_left <= 0) begin
				seg_left = $urandom_range(6, 14);
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 25;
					default: idle_pct = 60;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					default: stall_pct = 60;
				endcase
			end
			send_token();
			seg_left--;
		end

		// last part, no idling: a long ident, then a run of line breaks
		idle_pct  = 0;
		stall_pct = 0;
		send_byte(CH_SPACE, 1'b1);
		send_byte(CH_LOWER_LO, 1'b0);
		repeat (LONG_RUN - 1) send_byte(name_char(1'b0), 1'b0);
		send_byte(CH_EQUALS, 1'b0);
		repeat (LINE_RUN) send_byte(CH_LF, 1'b0);
		send_byte(CH_LT, 1'b1);
		char_ch.valid <= 1'b0;

		// drain
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mlex_pkg.sv
rtl/core/mlex_char_if.sv
rtl/core/mlex_tok_if.sv
rtl/core/mlex_core.sv
rtl/core/mlex_obuf.sv
rtl/core/markup_lexer_with_positions_unit.sv
tb/tb_mlex_token_checker.sv
tb/tb_markup_lexer_with_positions_unit.sv
